FILE: rtl/core/kpl_pkg.sv
// Shared constants, types and helpers for the keyword prefix lookup block.
`timescale 1ns / 1ps
`default_nettype none
package kpl_pkg;

    // Default sizing
    localparam int MAX_ENTRIES_DEF    = 64;
    localparam int MAX_NAME_BYTES_DEF = 63;

    // Width of the byte position within a table row, addressed by char_pos
    localparam int ROW_POS_W = 6;

    // Item kinds
    localparam logic [1:0] KIND_TABLE_BYTE = 2'd0;
    localparam logic [1:0] KIND_HEADER     = 2'd1;
    localparam logic [1:0] KIND_QUERY      = 2'd2;

    // Lookup status codes
    localparam logic [2:0] ST_EXACT    = 3'd0;
    localparam logic [2:0] ST_ABBREV   = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_AMBIG    = 3'd3;
    localparam logic [2:0] ST_SHORT    = 3'd4;

    // Configuration register indexes
    localparam logic CFG_MIN_ABBREV     = 1'b0;
    localparam logic CFG_ENTRIES_IN_USE = 1'b1;

    // ASCII bounds
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // One lookup result
    typedef struct packed {
        logic [2:0] status;
        logic [5:0] index;
    } result_t;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return is_upper(c) || ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return is_upper(c) ? (c + CASE_OFFSET) : c;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/kpl_table.sv
// Keyword table storage: keyword bytes and per-entry headers, registered reads.
`timescale 1ns / 1ps
`default_nettype none
module kpl_table #(
    parameter int MAX_ENTRIES = kpl_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 byte_we,
    input  wire logic                                 hdr_we,
    input  wire logic [$clog2(MAX_ENTRIES)-1:0]       wr_entry,
    input  wire logic [kpl_pkg::ROW_POS_W-1:0]        wr_pos,
    input  wire logic [7:0]                           wr_byte,
    input  wire logic [15:0]                          wr_val,
    input  wire logic [5:0]                           wr_len,
    input  wire logic [$clog2(MAX_ENTRIES)-1:0]       rd_entry,
    input  wire logic [kpl_pkg::ROW_POS_W-1:0]        rd_pos,
    output logic [7:0]                                rd_byte,
    output logic [15:0]                               rd_val,
    output logic [5:0]                                rd_len
);

    localparam int KB_DEPTH = MAX_ENTRIES * (2 ** kpl_pkg::ROW_POS_W);

    logic [7:0]  kbyte_mem [KB_DEPTH];
    logic [21:0] hdr_mem   [MAX_ENTRIES];

    // Keyword byte memory, one row per entry
    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            kbyte_mem[{wr_entry, wr_pos}] <= wr_byte;
        end
        rd_byte <= kbyte_mem[{rd_entry, rd_pos}];
    end

    // Header memory: value and length
    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_mem[wr_entry] <= {wr_val, wr_len};
        end
        {rd_val, rd_len} <= hdr_mem[rd_entry];
    end

endmodule
`default_nettype wire

FILE: rtl/core/kpl_query.sv
// Query name buffer: lower-cases and stores name bytes, tracks size and first letter.
`timescale 1ns / 1ps
`default_nettype none
module kpl_query #(
    parameter int MAX_NAME_BYTES = kpl_pkg::MAX_NAME_BYTES_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     push,
    input  wire logic                                     last,
    input  wire logic [7:0]                               char_byte,
    input  wire logic [$clog2(MAX_NAME_BYTES)-1:0]        rd_addr,
    output logic [7:0]                                    rd_byte,
    output logic [$clog2(MAX_NAME_BYTES+1)-1:0]           name_size,
    output logic                                          name_letter
);

    localparam int QA_W = $clog2(MAX_NAME_BYTES);
    localparam int QL_W = $clog2(MAX_NAME_BYTES + 1);

    logic [7:0]      qmem [MAX_NAME_BYTES];
    logic [QL_W-1:0] qlen_reg, qlen_next;
    logic [QL_W-1:0] zero_pos_reg, zero_pos_next;
    logic            zero_seen_reg, zero_seen_next;
    logic            letter_reg, letter_next;
    logic            store;
    logic [7:0]      lc_byte;

    assign store   = push && (32'(qlen_reg) < MAX_NAME_BYTES);
    assign lc_byte = kpl_pkg::to_lower(char_byte);

    // Name bookkeeping including the byte now arriving
    always_comb
    begin
        qlen_next      = qlen_reg;
        zero_pos_next  = zero_pos_reg;
        zero_seen_next = zero_seen_reg;
        letter_next    = letter_reg;
        if (push && (qlen_reg == '0))
        begin
            letter_next = kpl_pkg::is_letter(char_byte);
        end
        if (store)
        begin
            qlen_next = qlen_reg + 1'b1;
            if ((lc_byte == 8'd0) && !zero_seen_reg)
            begin
                zero_seen_next = 1'b1;
                zero_pos_next  = qlen_reg;
            end
        end
    end

    // Name ends at its first zero byte
    assign name_size   = zero_seen_next ? zero_pos_next : qlen_next;
    assign name_letter = letter_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg      <= '0;
            zero_pos_reg  <= '0;
            zero_seen_reg <= 1'b0;
            letter_reg    <= 1'b0;
        end
        else if (push && last)
        begin
            qlen_reg      <= '0;
            zero_pos_reg  <= '0;
            zero_seen_reg <= 1'b0;
            letter_reg    <= 1'b0;
        end
        else
        begin
            qlen_reg      <= qlen_next;
            zero_pos_reg  <= zero_pos_next;
            zero_seen_reg <= zero_seen_next;
            letter_reg    <= letter_next;
        end
    end

    // Name byte memory
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            qmem[qlen_reg[QA_W-1:0]] <= lc_byte;
        end
        rd_byte <= qmem[rd_addr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/kpl_walk.sv
// Table walk sequencer: byte-serial compare of the name against each entry.
`timescale 1ns / 1ps
`default_nettype none
module kpl_walk #(
    parameter int MAX_ENTRIES    = kpl_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_NAME_BYTES = kpl_pkg::MAX_NAME_BYTES_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     start,
    input  wire logic [$clog2(MAX_NAME_BYTES+1)-1:0]      name_size,
    input  wire logic                                     name_letter,
    input  wire logic [$clog2(MAX_ENTRIES+1)-1:0]         entry_count,
    input  wire logic [5:0]                               min_abbrev,
    output logic [$clog2(MAX_ENTRIES)-1:0]                rd_entry,
    output logic [kpl_pkg::ROW_POS_W-1:0]                 rd_pos,
    output logic [$clog2(MAX_NAME_BYTES)-1:0]             rd_qaddr,
    input  wire logic [7:0]                               rd_byte,
    input  wire logic [15:0]                              rd_val,
    input  wire logic [5:0]                               rd_len,
    input  wire logic [7:0]                               rd_qbyte,
    output logic                                          busy,
    output logic                                          out_valid,
    input  wire logic                                     out_stall,
    output kpl_pkg::result_t                              out_result
);

    localparam int EIDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int QA_W   = $clog2(MAX_NAME_BYTES);
    localparam int QL_W   = $clog2(MAX_NAME_BYTES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_ENTRY = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  ent_reg, ent_next;
    logic [QA_W-1:0]   j_reg, j_next;
    logic [QL_W-1:0]   sz_reg, sz_next;
    logic              letter_reg, letter_next;
    logic              found_reg, found_next;
    logic [EIDX_W-1:0] best_reg, best_next;
    logic [15:0]       best_val_reg, best_val_next;
    kpl_pkg::result_t  res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    kpl_pkg::result_t  out_res_reg, out_res_next;

    logic [QA_W-1:0]   rd_j;
    logic [7:0]        kbyte;
    logic [6:0]        mini;
    kpl_pkg::result_t  fin_res;

    // Read addresses: first byte on entry, next byte while comparing
    assign rd_j     = (state_reg == S_CMP) ? (j_reg + 1'b1) : '0;
    assign rd_entry = ent_reg[EIDX_W-1:0];
    assign rd_pos   = kpl_pkg::ROW_POS_W'(rd_j);
    assign rd_qaddr = rd_j;

    // Keyword bytes past its length compare as zero
    assign kbyte = (32'(j_reg) < 32'(rd_len)) ? rd_byte : 8'd0;

    // Minimum abbreviation, one more for a non-letter first byte
    assign mini = ((min_abbrev == '0) ? 7'd1 : {1'b0, min_abbrev}) + {6'd0, ~letter_reg};

    // Outcome when the walk ends without an exact match
    always_comb
    begin
        fin_res.status = kpl_pkg::ST_NOTFOUND;
        fin_res.index  = '0;
        if (found_reg)
        begin
            if (32'(sz_reg) < 32'(mini))
            begin
                fin_res.status = kpl_pkg::ST_SHORT;
            end
            else
            begin
                fin_res.status = kpl_pkg::ST_ABBREV;
                fin_res.index  = 6'(best_reg);
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        ent_next      = ent_reg;
        j_next        = j_reg;
        sz_next       = sz_reg;
        letter_next   = letter_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        best_val_next = best_val_reg;
        res_next      = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    sz_next     = name_size;
                    letter_next = name_letter;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                ent_next   = '0;
                found_next = 1'b0;
                if ((sz_reg == '0) || (32'(sz_reg) >= MAX_NAME_BYTES))
                begin
                    res_next.status = kpl_pkg::ST_NOTFOUND;
                    res_next.index  = '0;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_ENTRY;
                end
            end
            S_ENTRY:
            begin
                j_next = '0;
                if (ent_reg == entry_count)
                begin
                    res_next   = fin_res;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (kbyte < rd_qbyte)
                begin
                    // entry sorts before the name: skip it
                    ent_next   = ent_reg + 1'b1;
                    state_next = S_ENTRY;
                end
                else if (kbyte > rd_qbyte)
                begin
                    // past every possible match
                    res_next   = fin_res;
                    state_next = S_EMIT;
                end
                else if ((32'(j_reg) + 1) == 32'(sz_reg))
                begin
                    // name is a prefix of this keyword
                    if (32'(rd_len) == 32'(sz_reg))
                    begin
                        res_next.status = kpl_pkg::ST_EXACT;
                        res_next.index  = 6'(ent_reg);
                        state_next      = S_EMIT;
                    end
                    else if (found_reg && (best_val_reg != rd_val))
                    begin
                        res_next.status = kpl_pkg::ST_AMBIG;
                        res_next.index  = '0;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        found_next    = 1'b1;
                        best_next     = ent_reg[EIDX_W-1:0];
                        best_val_next = rd_val;
                        ent_next      = ent_reg + 1'b1;
                        state_next    = S_ENTRY;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_EMIT) && (!out_valid_reg || !out_stall))
        begin
            out_valid_next = 1'b1;
            out_res_next   = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg      <= ent_next;
        j_reg        <= j_next;
        sz_reg       <= sz_next;
        letter_reg   <= letter_next;
        best_reg     <= best_next;
        best_val_reg <= best_val_next;
        res_reg      <= res_next;
        out_res_reg  <= out_res_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_result = out_res_reg;

endmodule
`default_nettype wire

FILE: rtl/core/keyword_prefix_lookup_core.sv
// Top level: keyword lookup with unique abbreviations over a loaded sorted table.
// Table byte, header and non-final query bytes are accepted whenever no walk is in progress.
// A final query byte starts the table walk; input stalls until the result is loaded into the
// output register. The byte-serial compare loop reads one keyword byte per cycle from the
// table memory.
// Reset clears configuration, name tracking and control; table contents are undefined.
`timescale 1ns / 1ps
`default_nettype none
module keyword_prefix_lookup_core #(
    parameter int MAX_ENTRIES    = kpl_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_NAME_BYTES = kpl_pkg::MAX_NAME_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data,
    // input items
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [5:0]  entry_index,
    input  wire logic [5:0]  char_pos,
    input  wire logic [7:0]  char_byte,
    input  wire logic [15:0] entry_value,
    input  wire logic [5:0]  entry_length,
    input  wire logic        query_last,
    // results
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [5:0]       match_index
);

    localparam int EIDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int QA_W   = $clog2(MAX_NAME_BYTES);
    localparam int QL_W   = $clog2(MAX_NAME_BYTES + 1);

    logic [5:0]        min_abbrev_reg;
    logic [6:0]        entries_in_use_reg;
    logic [CNT_W-1:0]  entry_count;
    logic              busy;
    logic              in_xfer;
    logic              entry_ok;
    logic              byte_we, hdr_we, q_push, q_start;
    logic [EIDX_W-1:0] rd_entry;
    logic [kpl_pkg::ROW_POS_W-1:0] rd_pos;
    logic [QA_W-1:0]   rd_qaddr;
    logic [7:0]        rd_byte, rd_qbyte;
    logic [15:0]       rd_val;
    logic [5:0]        rd_len;
    logic [QL_W-1:0]   name_size;
    logic              name_letter;
    kpl_pkg::result_t  result;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_abbrev_reg     <= '0;
            entries_in_use_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kpl_pkg::CFG_MIN_ABBREV:     min_abbrev_reg     <= cfg_data[5:0];
                kpl_pkg::CFG_ENTRIES_IN_USE: entries_in_use_reg <= cfg_data;
                default:                     min_abbrev_reg     <= min_abbrev_reg;
            endcase
        end
    end

    // Searched entries, capped at table size
    assign entry_count = (32'(entries_in_use_reg) >= MAX_ENTRIES) ?
                         CNT_W'(MAX_ENTRIES) : CNT_W'(entries_in_use_reg);

    // Item decode
    assign in_stall = busy;
    assign in_xfer  = in_valid && !in_stall;
    assign entry_ok = (32'(entry_index) < MAX_ENTRIES);
    assign byte_we  = in_xfer && (kind == kpl_pkg::KIND_TABLE_BYTE) && entry_ok;
    assign hdr_we   = in_xfer && (kind == kpl_pkg::KIND_HEADER) && entry_ok;
    assign q_push   = in_xfer && (kind == kpl_pkg::KIND_QUERY);
    assign q_start  = q_push && query_last;

    kpl_table #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_table (
        .clk      (clk),
        .byte_we  (byte_we),
        .hdr_we   (hdr_we),
        .wr_entry (EIDX_W'(entry_index)),
        .wr_pos   (char_pos),
        .wr_byte  (char_byte),
        .wr_val   (entry_value),
        .wr_len   (entry_length),
        .rd_entry (rd_entry),
        .rd_pos   (rd_pos),
        .rd_byte  (rd_byte),
        .rd_val   (rd_val),
        .rd_len   (rd_len)
    );

    kpl_query #(
        .MAX_NAME_BYTES (MAX_NAME_BYTES)
    ) u_query (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (q_push),
        .last        (query_last),
        .char_byte   (char_byte),
        .rd_addr     (rd_qaddr),
        .rd_byte     (rd_qbyte),
        .name_size   (name_size),
        .name_letter (name_letter)
    );

    kpl_walk #(
        .MAX_ENTRIES    (MAX_ENTRIES),
        .MAX_NAME_BYTES (MAX_NAME_BYTES)
    ) u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (q_start),
        .name_size   (name_size),
        .name_letter (name_letter),
        .entry_count (entry_count),
        .min_abbrev  (min_abbrev_reg),
        .rd_entry    (rd_entry),
        .rd_pos      (rd_pos),
        .rd_qaddr    (rd_qaddr),
        .rd_byte     (rd_byte),
        .rd_val      (rd_val),
        .rd_len      (rd_len),
        .rd_qbyte    (rd_qbyte),
        .busy        (busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_result  (result)
    );

    assign status      = result.status;
    assign match_index = result.index;

endmodule
`default_nettype wire

FILE: tb/sv/kpl_checker.sv
// Checker for the keyword lookup block: mirrors its table, predicts each lookup, compares results.
`timescale 1ns / 1ps
module kpl_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [5:0]  entry_index,
    input  wire logic [5:0]  char_pos,
    input  wire logic [7:0]  char_byte,
    input  wire logic [15:0] entry_value,
    input  wire logic [5:0]  entry_length,
    input  wire logic        query_last,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [2:0]  status,
    input  wire logic [5:0]  match_index,
    output int               fail_count,
    output int               pending
);

    localparam int ENTRY_MAX = kpl_pkg::MAX_ENTRIES_DEF;
    localparam int NAME_MAX  = kpl_pkg::MAX_NAME_BYTES_DEF;

    // Mirror of the keyword table and the name being collected
    logic [7:0]  kw_mem [0:4095];
    logic [15:0] kw_value [0:63];
    logic [5:0]  kw_len [0:63];
    logic [7:0]  name_buf [0:62];
    logic [6:0]  name_len;
    logic        name_alpha;
    logic [5:0]  shortest_cfg;
    logic [6:0]  active_cfg;
    kpl_pkg::result_t lookup_q [$];

    // Order of keyword e against the first sz name bytes: -1 below, 0 prefix, +1 above
    function automatic int entry_order(input int e, input int sz);
        logic [7:0] kb;
        for (int j = 0; j < sz; j++) begin
            kb = (j < kw_len[e]) ? kw_mem[e * 64 + j] : 8'h00;
            if (kb < name_buf[j])
                return -1;
            if (kb > name_buf[j])
                return 1;
        end
        return 0;
    endfunction

    // Walk the sorted table for the collected name
    function automatic kpl_pkg::result_t predict_lookup();
        kpl_pkg::result_t r;
        int      sz;
        int      limit;
        int      best;
        int      shortest;
        int      ord;
        bit      found;
        bit      done;
        r.status = kpl_pkg::ST_NOTFOUND;
        r.index  = '0;
        sz       = name_len;
        // name ends at its first zero byte
        for (int i = sz - 1; i >= 0; i--)
            if (name_buf[i] == 8'h00)
                sz = i;
        if (sz == 0 || sz >= NAME_MAX)
            return r;
        limit = (active_cfg > ENTRY_MAX) ? ENTRY_MAX : active_cfg;
        found = 1'b0;
        done  = 1'b0;
        best  = 0;
        for (int i = 0; i < limit && !done; i++) begin
            ord = entry_order(i, sz);
            if (ord > 0)
                done = 1'b1;
            else if (ord == 0) begin
                if (kw_len[i] == sz) begin
                    r.status = kpl_pkg::ST_EXACT;
                    r.index  = i[5:0];
                    return r;
                end
                if (found && kw_value[best] != kw_value[i]) begin
                    r.status = kpl_pkg::ST_AMBIG;
                    return r;
                end
                best  = i;
                found = 1'b1;
            end
        end
        if (!found)
            return r;
        shortest = (shortest_cfg == 0) ? 1 : shortest_cfg;
        if (!name_alpha)
            shortest++;
        if (sz < shortest) begin
            r.status = kpl_pkg::ST_SHORT;
            return r;
        end
        r.status = kpl_pkg::ST_ABBREV;
        r.index  = best[5:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        kpl_pkg::result_t want;
        logic [7:0]       folded;
        if (!rst_n) begin
            name_len     = '0;
            name_alpha   = 1'b0;
            shortest_cfg = '0;
            active_cfg   = '0;
            lookup_q.delete();
            fail_count   = 0;
            pending      = 0;
        end
        else begin
            // result transfer against the oldest prediction
            if (out_valid && !out_stall) begin
                if (lookup_q.size() == 0) begin
                    $error("unexpected result: status %0d match_index %0d", status, match_index);
                    fail_count++;
                end
                else begin
                    want = lookup_q.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (match_index !== want.index) begin
                        $error("match_index: expected %0d, got %0d", want.index, match_index);
                        fail_count++;
                    end
                end
            end
            // register write
            if (cfg_we) begin
                if (cfg_index == kpl_pkg::CFG_MIN_ABBREV)
                    shortest_cfg = cfg_data[5:0];
                else
                    active_cfg = cfg_data;
            end
            // input transfer
            if (in_valid && !in_stall) begin
                case (kind)
                    kpl_pkg::KIND_TABLE_BYTE: kw_mem[{entry_index, char_pos}] = char_byte;
                    kpl_pkg::KIND_HEADER: begin
                        kw_value[entry_index] = entry_value;
                        kw_len[entry_index]   = entry_length;
                    end
                    kpl_pkg::KIND_QUERY: begin
                        if (name_len == 0)
                            name_alpha = (char_byte >= kpl_pkg::CHAR_UPPER_A
                                          && char_byte <= kpl_pkg::CHAR_UPPER_Z)
                                || (char_byte >= kpl_pkg::CHAR_LOWER_A
                                    && char_byte <= kpl_pkg::CHAR_LOWER_Z);
                        if (name_len < NAME_MAX) begin
                            folded = (char_byte >= kpl_pkg::CHAR_UPPER_A
                                      && char_byte <= kpl_pkg::CHAR_UPPER_Z)
                                ? char_byte + kpl_pkg::CASE_OFFSET : char_byte;
                            name_buf[name_len] = folded;
                            name_len++;
                        end
                        if (query_last) begin
                            lookup_q.push_back(predict_lookup());
                            name_len   = '0;
                            name_alpha = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            pending = lookup_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top: loads a sorted keyword table, sends lookups and register writes, gives the verdict.
`timescale 1ns / 1ps
module tb_top;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int TABLE_N       = 10;
    localparam int WORD_MAX      = 3;
    localparam int LONG_LEN      = kpl_pkg::MAX_NAME_BYTES_DEF;
    localparam int ROW_BYTES     = 1 << kpl_pkg::ROW_POS_W;
    localparam int IDLE_LIMIT    = 20000;
    localparam int SETTLE_CYCLES = 16;
    localparam int BATCH_BYTES   = 8;

    // letter case handling when building names
    localparam int CASE_KEEP  = 0;
    localparam int CASE_MIX   = 1;
    localparam int CASE_UPPER = 2;

    // receiver stall patterns
    localparam int STALL_NONE   = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_RUNS   = 2;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [6:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [5:0]  entry_index;
    logic [5:0]  char_pos;
    logic [7:0]  char_byte;
    logic [15:0] entry_value;
    logic [5:0]  entry_length;
    logic        query_last;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [5:0]  match_index;
    int          fail_count;
    int          pending;

    // table as loaded, kept to build names from
    logic [7:0]  word_mem [0:TABLE_N*ROW_BYTES-1];
    int          word_len [0:TABLE_N-1];
    logic [15:0] word_value [0:TABLE_N-1];
    int          some_entry;
    int          entries_now;
    logic [7:0]  charset [0:7];

    // name to send
    logic [7:0]  name [0:LONG_LEN+1];
    int          name_n;

    int          burst_left;
    int          calm_left;
    bit          calm;
    int          idle_cycles;
    int          stall_mode;
    int          mode_left;
    int          run_left;
    bit          stall_hold;

    keyword_prefix_lookup_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .entry_index  (entry_index),
        .char_pos     (char_pos),
        .char_byte    (char_byte),
        .entry_value  (entry_value),
        .entry_length (entry_length),
        .query_last   (query_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .match_index  (match_index)
    );

    kpl_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .entry_index  (entry_index),
        .char_pos     (char_pos),
        .char_byte    (char_byte),
        .entry_value  (entry_value),
        .entry_length (entry_length),
        .query_last   (query_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .match_index  (match_index),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #1 clk = ~clk;

    // Receiver back-pressure, switching between patterns
    always @(negedge clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_RUNS);
            mode_left  = $urandom_range(16, 96);
        end
        mode_left--;
        if (run_left == 0) begin
            stall_hold = ~stall_hold;
            run_left   = $urandom_range(1, 12);
        end
        run_left--;
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
            default:      out_stall <= stall_hold;
        endcase
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // One input transfer; called and returns at a falling edge
    task automatic push_item(input logic [1:0] k, input logic [5:0] idx, input logic [5:0] pos,
                             input logic [7:0] b, input logic [15:0] v, input logic [5:0] len,
                             input logic last);
        int gap;
        if (calm_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(10, 40);
        end
        calm_left--;
        if (!calm && burst_left == 0) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid     <= 1'b1;
        kind         <= k;
        entry_index  <= idx;
        char_pos     <= pos;
        char_byte    <= b;
        entry_value  <= v;
        entry_length <= len;
        query_last   <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_name();
        for (int i = 0; i < name_n; i++)
            push_item(kpl_pkg::KIND_QUERY, 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 62)), name[i], 16'($urandom),
                      6'($urandom_range(0, 63)), (i == name_n - 1));
    endtask

    task automatic push_spare();
        push_item(KIND_SPARE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 62)),
                  8'($urandom), 16'($urandom), 6'($urandom_range(0, 63)),
                  1'($urandom_range(0, 1)));
    endtask

    // Hold off input until every lookup has returned
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    task automatic drain();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(input logic [5:0] shortest, input logic [6:0] active);
        cfg_we    <= 1'b1;
        cfg_index <= kpl_pkg::CFG_MIN_ABBREV;
        cfg_data  <= {1'b0, shortest};
        @(negedge clk);
        cfg_index <= kpl_pkg::CFG_ENTRIES_IN_USE;
        cfg_data  <= active;
        @(negedge clk);
        cfg_we    <= 1'b0;
        entries_now = int'(active);
    endtask

    // Keyword a sorts strictly below keyword b (zero padded)
    function automatic bit word_before(input int a, input int b);
        for (int j = 0; j < WORD_MAX; j++)
            if (word_mem[a * ROW_BYTES + j] != word_mem[b * ROW_BYTES + j])
                return word_mem[a * ROW_BYTES + j] < word_mem[b * ROW_BYTES + j];
        return 1'b0;
    endfunction

    // Draw short keywords, sort them and load them
    task automatic load_table(input int value_span);
        int          e;
        int          j;
        int          t_len;
        logic [15:0] t_val;
        logic [7:0]  t_byte;
        for (e = 0; e < TABLE_N; e++) begin
            word_len[e] = 0;
            if (e == 0 || $urandom_range(0, 7) != 0)
                word_len[e] = $urandom_range(1, WORD_MAX);
            word_value[e] = 16'($urandom_range(0, value_span));
            for (j = 0; j < WORD_MAX; j++)
                word_mem[e * ROW_BYTES + j] = (j < word_len[e]) ? charset[$urandom_range(0, 7)]
                                                                 : 8'h00;
        end
        // insertion sort in byte order
        for (int i = 1; i < TABLE_N; i++) begin
            j = i;
            while (j > 0 && word_before(j, j - 1)) begin
                t_len           = word_len[j];
                word_len[j]     = word_len[j - 1];
                word_len[j - 1] = t_len;
                t_val             = word_value[j];
                word_value[j]     = word_value[j - 1];
                word_value[j - 1] = t_val;
                for (int p = 0; p < WORD_MAX; p++) begin
                    t_byte                             = word_mem[j * ROW_BYTES + p];
                    word_mem[j * ROW_BYTES + p]        = word_mem[(j - 1) * ROW_BYTES + p];
                    word_mem[(j - 1) * ROW_BYTES + p]  = t_byte;
                end
                j--;
            end
        end
        for (e = 0; e < TABLE_N; e++)
            if (word_len[e] > 0)
                some_entry = e;
        // header, keyword bytes, sometimes a stale byte past the end that must read as zero
        for (e = 0; e < TABLE_N; e++) begin
            push_item(kpl_pkg::KIND_HEADER, 6'(e), 6'($urandom_range(0, 62)), 8'($urandom),
                      word_value[e], 6'(word_len[e]), 1'($urandom_range(0, 1)));
            for (j = 0; j < word_len[e]; j++)
                push_item(kpl_pkg::KIND_TABLE_BYTE, 6'(e), 6'(j), word_mem[e * ROW_BYTES + j],
                          16'($urandom), 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            if (word_len[e] < WORD_MAX && $urandom_range(0, 1) == 1)
                push_item(kpl_pkg::KIND_TABLE_BYTE, 6'(e), 6'(word_len[e]),
                          8'($urandom_range(1, 255)), 16'($urandom),
                          6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Name from the first plen bytes of keyword e
    task automatic make_prefix(input int e, input int plen, input int case_mode);
        logic [7:0] b;
        name_n = plen;
        for (int i = 0; i < plen; i++) begin
            b = word_mem[e * ROW_BYTES + i];
            if (b >= kpl_pkg::CHAR_LOWER_A && b <= kpl_pkg::CHAR_LOWER_Z
                && (case_mode == CASE_UPPER || (case_mode == CASE_MIX && $urandom_range(0, 1))))
                b = b - kpl_pkg::CASE_OFFSET;
            name[i] = b;
        end
    endtask

    // Random non-empty keyword among the entries searched
    function automatic int pick_word();
        int n;
        int e;
        n = (entries_now == 0 || entries_now > TABLE_N) ? TABLE_N : entries_now;
        e = $urandom_range(0, n - 1);
        for (int k = 0; k < 8 && word_len[e] == 0; k++)
            e = $urandom_range(0, n - 1);
        return (word_len[e] == 0) ? some_entry : e;
    endfunction

    // One random lookup, or a spare item now and then; returns name bytes sent
    task automatic random_lookup(output int sent);
        int pick;
        int e;
        pick = $urandom_range(0, 99);
        e    = pick_word();
        if (pick < 50)
            make_prefix(e, $urandom_range(1, word_len[e]), CASE_MIX);
        else if (pick < 65)
            make_prefix(e, word_len[e], CASE_MIX);
        else if (pick < 77) begin
            make_prefix(e, $urandom_range(1, word_len[e]), CASE_MIX);
            name[name_n] = charset[$urandom_range(0, 7)];
            name_n++;
        end
        else if (pick < 87) begin
            name_n = $urandom_range(1, 3);
            for (int i = 0; i < name_n; i++)
                name[i] = 8'($urandom_range(0, 255));
        end
        else if (pick < 95) begin
            make_prefix(e, $urandom_range(1, word_len[e]), CASE_MIX);
            name[name_n] = charset[$urandom_range(0, 7)];
            name_n++;
            name[$urandom_range(0, name_n - 1)] = 8'h00;
        end
        else begin
            push_spare();
            name_n = 0;
        end
        sent = name_n;
        if (name_n > 0)
            send_name();
    endtask

    task automatic random_batch(input bit with_pause);
        int total;
        int sent;
        bit paused;
        total  = 0;
        paused = 1'b0;
        while (total < BATCH_BYTES) begin
            random_lookup(sent);
            total += sent;
            if (with_pause && !paused && total >= BATCH_BYTES / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        int e;
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = kpl_pkg::CFG_MIN_ABBREV;
        cfg_data     = '0;
        in_valid     = 1'b0;
        kind         = kpl_pkg::KIND_TABLE_BYTE;
        entry_index  = '0;
        char_pos     = '0;
        char_byte    = '0;
        entry_value  = '0;
        entry_length = '0;
        query_last   = 1'b0;
        out_stall    = 1'b0;
        burst_left   = 0;
        calm_left    = 0;
        calm         = 1'b1;
        idle_cycles  = 0;
        stall_mode   = STALL_NONE;
        mode_left    = 0;
        run_left     = 0;
        stall_hold   = 1'b0;
        entries_now  = 0;
        some_entry   = 0;
        charset[0] = "a";
        charset[1] = "b";
        charset[2] = "c";
        charset[3] = "d";
        charset[4] = "-";
        charset[5] = "0";
        charset[6] = "z";
        charset[7] = 8'he9;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty search range: nothing is found; few distinct values in the table
        set_config(6'd0, 7'd0);
        load_table(2);
        name[0] = "a";
        name_n  = 1;
        send_name();
        push_spare();
        drain();

        // whole table, default minimum
        set_config(6'd0, 7'(TABLE_N));
        e = pick_word();
        // whole keyword in upper case
        make_prefix(e, word_len[e], CASE_UPPER);
        send_name();
        // single letter: unique, ambiguous or too short
        make_prefix(e, 1, CASE_KEEP);
        send_name();
        // empty name
        name[0] = 8'h00;
        name_n  = 1;
        send_name();
        // name cut short by a zero byte
        name[0] = word_mem[e * ROW_BYTES];
        name[1] = 8'h00;
        name[2] = "z";
        name_n  = 3;
        send_name();
        // non-letter first byte raises the minimum
        name[0] = "-";
        name_n  = 1;
        send_name();
        name[0] = 8'hff;
        send_name();
        // bytes beyond the limit are dropped and the name is not found
        name_n = LONG_LEN + 1;
        for (int i = 0; i < name_n; i++)
            name[i] = charset[$urandom_range(0, 7)];
        send_name();
        push_spare();
        random_batch(1'b0);
        drain();

        // largest minimum: every abbreviation is too short
        set_config(6'd63, 7'(TABLE_N));
        random_batch(1'b0);
        drain();

        // partial search range
        set_config(6'($urandom_range(2, 5)), 7'(TABLE_N - 3));
        random_batch(1'b1);
        drain();

        set_config(6'd1, 7'(TABLE_N));
        random_batch(1'b0);
        drain();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/kpl_pkg.sv
rtl/core/kpl_table.sv
rtl/core/kpl_query.sv
rtl/core/kpl_walk.sv
rtl/core/keyword_prefix_lookup_core.sv
tb/sv/kpl_checker.sv
tb/sv/tb_top.sv
